@@ rtl/core/npsched_pkg.sv @@
package npsched_pkg;

    // Field widths of the stream payloads.
    localparam int ARR_W    = 16;
    localparam int BURST_W  = 16;
    localparam int PRI_W    = 8;
    localparam int JOBNUM_W = 5;
    localparam int TIME_W   = 21;
    localparam int TOT_W    = 25;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 144;

    // Job index carried by the selection token, sized for the largest batch (64 jobs).
    localparam int JOB_IDX_W = 6;

    // Selection token that walks down the row of cells.
    typedef struct packed {
        logic                 valid;
        logic                 pick_valid;
        logic                 pend_valid;
        logic [PRI_W-1:0]     priority_val;
        logic [ARR_W-1:0]     arrival;
        logic [BURST_W-1:0]   burst;
        logic [JOB_IDX_W-1:0] idx;
        logic [ARR_W-1:0]     earliest;
    } token_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic start_we;
        logic shift;
        logic clear_done;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_CALC = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_SHOW = 6'b100000
    } state_t;

endpackage

@@ rtl/core/nonpreemptive_priority_scheduler_core.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata: arrival_time, burst_time, priority_req; tlast: last
// m_axis   | out       | tdata: job_number .. total_waiting; tlast: last_result
//
// Loading stores one job per accepted beat; jobs beyond MAX_JOBS are dropped.
// Each selection is one pass of a token down the row of cells;
// a batch of n jobs needs between n and 2n passes (idle gaps add a pass each).
// Each result is formed in the CALC, FIN and SUM states and is then held
// in SHOW until m_tready; the next result is formed only after that.
// Reset clears all control state; no clearing pass is needed.
// Input is stalled while a batch is scheduled or its results are out.
module nonpreemptive_priority_scheduler_core
    import npsched_pkg::*;
#(
    parameter int MAX_JOBS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [15:0] arrival_time, [31:16] burst_time, [39:32] priority_req
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [4:0] job_number, [25:5] run_start, [46:26] completion_time,
    // [67:47] turnaround, [88:68] waiting, [113:89] total_turnaround,
    // [138:114] total_waiting, [143:139] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);
    localparam int CLK_W = ARR_W + $clog2(MAX_JOBS + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   remain_reg, remain_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [CLK_W-1:0]   clock_reg, clock_next;
    logic               launch_reg, launch_next;
    logic               mvalid_reg, mvalid_next;
    logic               last_reg, last_next;
    logic [CLK_W-1:0]   st_reg, st_next;
    logic [CLK_W-1:0]   ct_reg, ct_next;
    logic [CLK_W-1:0]   wt_reg, wt_next;
    logic [CLK_W-1:0]   tat_reg, tat_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic [TOT_W-1:0]   tot_tat_reg, tot_tat_next;
    logic [TOT_W-1:0]   tot_wt_reg, tot_wt_next;

    logic [MAX_JOBS-1:0] load_vec;
    logic [MAX_JOBS-1:0] start_vec;
    logic                shift_en;
    logic                clear_done;

    logic               occ_chain   [MAX_JOBS];
    logic [ARR_W-1:0]   arr_chain   [MAX_JOBS];
    logic [BURST_W-1:0] burst_chain [MAX_JOBS];
    logic [CLK_W-1:0]   start_chain [MAX_JOBS];
    token_t             tok_chain   [MAX_JOBS];
    token_t             tok_head;
    token_t             tok_end;

    // Token entering cell 0 starts a fresh selection pass.
    always_comb
    begin
        tok_head       = '0;
        tok_head.valid = launch_reg;
    end

    assign tok_end = tok_chain[MAX_JOBS-1];

    // Row of job cells.
    for (genvar i = 0; i < MAX_JOBS; i++)
    begin : g_cell
        cell_ctl_t ctl;
        always_comb
        begin
            ctl.load       = load_vec[i];
            ctl.start_we   = start_vec[i];
            ctl.shift      = shift_en;
            ctl.clear_done = clear_done;
        end
        if (i == MAX_JOBS - 1)
        begin : g_tail
            npsched_cell #(.CELL_IDX(i), .CLK_W(CLK_W)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .load_arrival  (s_tdata[15:0]),
                .load_burst    (s_tdata[31:16]),
                .load_priority (s_tdata[39:32]),
                .start_value   (clock_reg),
                .clock_now     (clock_reg),
                .shift_occ     (1'b0),
                .shift_arrival ('0),
                .shift_burst   ('0),
                .shift_start   ('0),
                .tok_in        ((i == 0) ? tok_head : tok_chain[(i == 0) ? 0 : i - 1]),
                .occ           (occ_chain[i]),
                .arrival       (arr_chain[i]),
                .burst         (burst_chain[i]),
                .start         (start_chain[i]),
                .tok_out       (tok_chain[i])
            );
        end
        else
        begin : g_body
            npsched_cell #(.CELL_IDX(i), .CLK_W(CLK_W)) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctl           (ctl),
                .load_arrival  (s_tdata[15:0]),
                .load_burst    (s_tdata[31:16]),
                .load_priority (s_tdata[39:32]),
                .start_value   (clock_reg),
                .clock_now     (clock_reg),
                .shift_occ     (occ_chain[i+1]),
                .shift_arrival (arr_chain[i+1]),
                .shift_burst   (burst_chain[i+1]),
                .shift_start   (start_chain[i+1]),
                .tok_in        ((i == 0) ? tok_head : tok_chain[(i == 0) ? 0 : i - 1]),
                .occ           (occ_chain[i]),
                .arrival       (arr_chain[i]),
                .burst         (burst_chain[i]),
                .start         (start_chain[i]),
                .tok_out       (tok_chain[i])
            );
        end
    end

    // Sequencer: load, select, then form and hand out results.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        emit_next    = emit_reg;
        clock_next   = clock_reg;
        launch_next  = 1'b0;
        mvalid_next  = mvalid_reg;
        last_next    = last_reg;
        st_next      = st_reg;
        ct_next      = ct_reg;
        wt_next      = wt_reg;
        tat_next     = tat_reg;
        burst_next   = burst_reg;
        tot_tat_next = tot_tat_reg;
        tot_wt_next  = tot_wt_reg;
        load_vec     = '0;
        start_vec    = '0;
        shift_en     = 1'b0;
        clear_done   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_tvalid)
                begin
                    if (count_reg < CNT_W'(MAX_JOBS))
                    begin
                        for (int i = 0; i < MAX_JOBS; i++)
                        begin
                            load_vec[i] = (count_reg == CNT_W'(i));
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast)
                    begin
                        clear_done   = 1'b1;
                        remain_next  = count_next;
                        emit_next    = '0;
                        clock_next   = '0;
                        tot_tat_next = '0;
                        tot_wt_next  = '0;
                        launch_next  = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (tok_end.valid)
                begin
                    if (tok_end.pick_valid)
                    begin
                        for (int i = 0; i < MAX_JOBS; i++)
                        begin
                            start_vec[i] = (tok_end.idx == JOB_IDX_W'(i));
                        end
                        clock_next  = clock_reg + CLK_W'(tok_end.burst);
                        remain_next = remain_reg - CNT_W'(1);
                        if (remain_reg == CNT_W'(1))
                        begin
                            state_next = ST_CALC;
                        end
                        else
                        begin
                            launch_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // Nothing ready: jump to the earliest pending arrival.
                        clock_next  = CLK_W'(tok_end.earliest);
                        launch_next = 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                st_next    = start_chain[0];
                ct_next    = start_chain[0] + CLK_W'(burst_chain[0]);
                wt_next    = start_chain[0] - CLK_W'(arr_chain[0]);
                burst_next = burst_chain[0];
                shift_en   = 1'b1;
                emit_next  = emit_reg + CNT_W'(1);
                last_next  = ((emit_reg + CNT_W'(1)) == count_reg);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                tat_next    = wt_reg + CLK_W'(burst_reg);
                tot_wt_next = tot_wt_reg + TOT_W'(wt_reg);
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                tot_tat_next = tot_tat_reg + TOT_W'(tat_reg);
                mvalid_next  = 1'b1;
                state_next   = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (m_tready)
                begin
                    mvalid_next = 1'b0;
                    if (last_reg)
                    begin
                        count_next = '0;
                        emit_next  = '0;
                        clock_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            remain_reg <= '0;
            emit_reg   <= '0;
            clock_reg  <= '0;
            launch_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            emit_reg   <= emit_next;
            clock_reg  <= clock_next;
            launch_reg <= launch_next;
            mvalid_reg <= mvalid_next;
            last_reg   <= last_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        st_reg      <= st_next;
        ct_reg      <= ct_next;
        wt_reg      <= wt_next;
        tat_reg     <= tat_next;
        burst_reg   <= burst_next;
        tot_tat_reg <= tot_tat_next;
        tot_wt_reg  <= tot_wt_next;
    end

    // Stream ports.
    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = mvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'b00000,
                       tot_wt_reg,
                       tot_tat_reg,
                       TIME_W'(wt_reg),
                       TIME_W'(tat_reg),
                       TIME_W'(ct_reg),
                       TIME_W'(st_reg),
                       JOBNUM_W'(emit_reg)};

    // Jobs still to schedule never exceed the stored batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg <= count_reg)
    else $error("remaining job count exceeds batch size");

    // At most one cell takes a start time per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(start_vec))
    else $error("more than one start write");

    // A pass with no eligible job still has a pending one to jump to.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && tok_end.valid && !tok_end.pick_valid) |-> tok_end.pend_valid)
    else $error("selection pass found no pending job");

    // Results handed out never exceed the stored batch.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg <= count_reg)
    else $error("result count exceeds batch size");

endmodule

@@ rtl/core/npsched_cell.sv @@
module npsched_cell
    import npsched_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CLK_W    = 21
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [ARR_W-1:0]   load_arrival,
    input  logic [BURST_W-1:0] load_burst,
    input  logic [PRI_W-1:0]   load_priority,
    input  logic [CLK_W-1:0]   start_value,
    input  logic [CLK_W-1:0]   clock_now,
    input  logic               shift_occ,
    input  logic [ARR_W-1:0]   shift_arrival,
    input  logic [BURST_W-1:0] shift_burst,
    input  logic [CLK_W-1:0]   shift_start,
    input  token_t             tok_in,
    output logic               occ,
    output logic [ARR_W-1:0]   arrival,
    output logic [BURST_W-1:0] burst,
    output logic [CLK_W-1:0]   start,
    output token_t             tok_out
);

    logic               occ_reg;
    logic               done_reg;
    logic [ARR_W-1:0]   arrival_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRI_W-1:0]   priority_reg;
    logic [CLK_W-1:0]   start_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               live;
    logic               eligible;
    logic               better;

    // Occupancy and finished flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (ctl.load)
            begin
                occ_reg <= 1'b1;
            end
            else if (ctl.shift)
            begin
                occ_reg <= shift_occ;
            end
            if (ctl.clear_done || ctl.shift)
            begin
                done_reg <= 1'b0;
            end
            else if (ctl.start_we)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Job payload: written on load, moved toward cell 0 while results go out.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            arrival_reg  <= load_arrival;
            burst_reg    <= load_burst;
            priority_reg <= load_priority;
        end
        else if (ctl.shift)
        begin
            arrival_reg <= shift_arrival;
            burst_reg   <= shift_burst;
        end
        if (ctl.start_we)
        begin
            start_reg <= start_value;
        end
        else if (ctl.shift)
        begin
            start_reg <= shift_start;
        end
    end

    // Compare this job against the best candidate seen so far in the token, and track the earliest pending arrival.
    always_comb
    begin
        live     = occ_reg && !done_reg;
        eligible = live && (CLK_W'(arrival_reg) <= clock_now);
        better   = !tok_in.pick_valid
                   || (priority_reg > tok_in.priority_val)
                   || ((priority_reg == tok_in.priority_val)
                       && (arrival_reg < tok_in.arrival));
        tok_next = tok_in;
        if (live && (!tok_in.pend_valid || (arrival_reg < tok_in.earliest)))
        begin
            tok_next.pend_valid = 1'b1;
            tok_next.earliest   = arrival_reg;
        end
        if (eligible && better)
        begin
            tok_next.pick_valid   = 1'b1;
            tok_next.priority_val = priority_reg;
            tok_next.arrival      = arrival_reg;
            tok_next.burst        = burst_reg;
            tok_next.idx          = JOB_IDX_W'(CELL_IDX);
        end
    end

    // Token register toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign occ     = occ_reg;
    assign arrival = arrival_reg;
    assign burst   = burst_reg;
    assign start   = start_reg;
    assign tok_out = tok_reg;

endmodule
